>>> hdl/rhdf_pkg.sv
// rhdf_pkg: shared constants and types for the recent-digest duplicate filter.
// No dependencies.
package rhdf_pkg;
	localparam int unsigned DefCapacity = 1024;
	localparam int unsigned DefBuckets  = 2047;
	localparam int unsigned WordW       = 64;
	localparam int unsigned BinKeyW     = 32;

	typedef enum logic [0:0] {
		CMD_ADD    = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIN,
		ST_READ,
		ST_CMP,
		ST_DONE
	} state_t;
endpackage

>>> hdl/recent_hash_dedup_filter_core.sv
// recent_hash_dedup_filter_core: top level of the recent-digest duplicate filter.
// Depends on rhdf_pkg and rhdf_store.
//
//  channel | signals                                  | dir
//  in      | in_valid/in_ready, cmd, key_word0..3     | sink
//  out     | out_valid/out_ready, op_done, found      | source
//
// Add: accept, the bin steps (the last writes the row), then the result load in ST_DONE.
// Lookup: a read and a compare per held entry, stopping at the first match; at worst all
// CAPACITY entries, set by the single read port of the store walked oldest to newest.
// Bin: low 32 key bits times a reciprocal, then one multiply-back and one correction.
// Reset empties the history at once (fill count zero); no clearing pass.
// Beats are taken only in idle; a held output result stalls the next one in ST_DONE.
module recent_hash_dedup_filter_core import rhdf_pkg::*; #(
	parameter int unsigned CAPACITY = DefCapacity,
	parameter int unsigned BUCKETS  = DefBuckets
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [63:0] key_word0,
	input  logic [63:0] key_word1,
	input  logic [63:0] key_word2,
	input  logic [63:0] key_word3,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        op_done,
	output logic        found
);
	localparam int unsigned SlotW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CntW  = $clog2(CAPACITY + 1);
	localparam int unsigned BinW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int unsigned RemW  = BinW + 1;
	localparam int unsigned StepW = 2;
	localparam logic [SlotW-1:0] SlotLast = SlotW'(CAPACITY - 1);
	localparam logic [CntW-1:0]  CntFull  = CntW'(CAPACITY);
	localparam logic [RemW-1:0]  BucketsR = RemW'(BUCKETS);
	localparam logic [StepW-1:0] StepFirst = StepW'(2);
	localparam logic [BinKeyW:0] Recip =
		(BinKeyW+1)'((64'd1 << BinKeyW) / 64'(BUCKETS));
	localparam logic [BinKeyW-1:0] BucketsK = BinKeyW'(BUCKETS);

	state_t state_q, state_d;
	logic [SlotW-1:0] oldest_q, walk_slot_q, rd_slot;
	logic [CntW-1:0]  fill_q, walk_cnt_q;
	logic [4*WordW-1:0] key_q, rd_key;
	logic [BinW-1:0]  rd_bin;
	logic [RemW-1:0]  rem_q;
	logic [StepW-1:0] step_q;
	logic             cmd_q, hit_q, out_valid_q, op_q, found_q;
	logic [RemW-1:0]  rem_sh;
	logic [BinW-1:0]  bin;
	logic             wr_en;
	logic [SlotW-1:0] wr_slot, tail;
	logic [CntW:0]    tail_sum;
	logic [2*BinKeyW-1:0] prod_q;
	logic [BinKeyW-1:0]   qb_q, key_lo, quot_est, diff;

	// bin: quotient estimate is low by at most one, so one subtract finishes it
	assign key_lo = key_q[BinKeyW-1:0];
	assign quot_est = prod_q[2*BinKeyW-1 -: BinKeyW];
	assign diff = key_lo - qb_q;
	always_comb begin
		rem_sh = RemW'(diff);
		if (rem_sh >= BucketsR) rem_sh = rem_sh - BucketsR;
	end
	assign bin = rem_q[BinW-1:0];

	assign tail_sum = {1'b0, fill_q} + (CntW+1)'(oldest_q);
	assign tail = (tail_sum >= (CntW+1)'(CAPACITY)) ?
		SlotW'(tail_sum - (CntW+1)'(CAPACITY)) : SlotW'(tail_sum);
	assign wr_slot = (fill_q == CntFull) ? oldest_q : tail;
	assign wr_en = (state_q == ST_BIN) && (step_q == '0) && (cmd_q == CMD_ADD);
	assign rd_slot = walk_slot_q;

	rhdf_store #(.CAPACITY(CAPACITY), .BIN_W(BinW), .SLOT_W(SlotW)) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_slot(wr_slot),
		.wr_key (key_q),
		.wr_bin (BinW'(rem_sh)),
		.rd_slot(rd_slot),
		.rd_key (rd_key),
		.rd_bin (rd_bin)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign op_done = op_q;
	assign found = found_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_BIN;
			ST_BIN: begin
				if (step_q == '0) begin
					if (cmd_q == CMD_ADD || fill_q == '0) state_d = ST_DONE;
					else state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_CMP;
			ST_CMP: begin
				if ((rd_bin == bin && rd_key == key_q) || walk_cnt_q == CntW'(1))
					state_d = ST_DONE;
				else state_d = ST_READ;
			end
			ST_DONE: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			oldest_q <= '0;
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			if (wr_en) begin
				if (fill_q == CntFull) oldest_q <= (oldest_q == SlotLast) ? '0 : oldest_q + 1'b1;
				else fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				key_q <= {key_word3, key_word2, key_word1, key_word0};
				cmd_q <= cmd;
				rem_q <= '0;
				step_q <= StepFirst;
				hit_q <= 1'b0;
			end
			ST_BIN: begin
				prod_q <= {{BinKeyW{1'b0}}, key_lo} * (2*BinKeyW)'(Recip);
				qb_q <= quot_est * BucketsK;
				rem_q <= rem_sh;
				step_q <= step_q - 1'b1;
				walk_slot_q <= oldest_q;
				walk_cnt_q <= fill_q;
			end
			ST_READ: ;
			ST_CMP: begin
				if (rd_bin == bin && rd_key == key_q) hit_q <= 1'b1;
				walk_slot_q <= (walk_slot_q == SlotLast) ? '0 : walk_slot_q + 1'b1;
				walk_cnt_q <= walk_cnt_q - 1'b1;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					op_q <= cmd_q;
					found_q <= (cmd_q == CMD_LOOKUP) && hit_q;
				end
			end
			default: ;
		endcase
	end

	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n) fill_q <= CntFull)
		else $error("fill count above capacity");
	a_add_no_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && op_q == CMD_ADD |-> !found_q)
		else $error("add reported found");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat taken while busy");
endmodule

>>> hdl/rhdf_store.sv
// rhdf_store: digest store, one 256-bit row per slot plus its bin tag.
// Depends on rhdf_pkg.
module rhdf_store import rhdf_pkg::*; #(
	parameter int unsigned CAPACITY = DefCapacity,
	parameter int unsigned BIN_W    = 11,
	parameter int unsigned SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [SLOT_W-1:0]    wr_slot,
	input  logic [4*WordW-1:0]   wr_key,
	input  logic [BIN_W-1:0]     wr_bin,
	input  logic [SLOT_W-1:0]    rd_slot,
	output logic [4*WordW-1:0]   rd_key,
	output logic [BIN_W-1:0]     rd_bin
);
	logic [4*WordW-1:0] key_mem [CAPACITY];
	logic [BIN_W-1:0]   bin_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_slot] <= wr_key;
			bin_mem[wr_slot] <= wr_bin;
		end
		rd_key <= key_mem[rd_slot];
		rd_bin <= bin_mem[rd_slot];
	end
endmodule
